[rtl/nested_der_header_parser_macros.svh]
// Assertion helpers used by the parse core.
`ifndef NESTED_DER_HEADER_PARSER_MACROS_SVH
`define NESTED_DER_HEADER_PARSER_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define NDHP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define NDHP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/ndhp_pkg.sv]
package ndhp_pkg;

    // Expected header tags.
    localparam logic [7:0] TAG_SEQUENCE = 8'h30;
    localparam logic [7:0] TAG_CONTEXT  = 8'ha0;
    localparam logic [7:0] TAG_OCTET    = 8'h04;

    // Length bytes above this value are long form; this value itself is short.
    localparam logic [7:0] LEN_LONG_MARK  = 8'h80;
    localparam logic [7:0] LEN_COUNT_MASK = 8'h7f;

    // Error status reported on the beat that causes the error.
    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_BAD_OUTER = 3'd1,
        ST_BAD_CTX   = 3'd2,
        ST_BAD_OCT   = 3'd3,
        ST_TOO_LONG  = 3'd4
    } t_status;

    // Per-beat result flags from the parse core.
    typedef struct packed {
        logic    payload_valid;
        logic    payload_last;
        logic    frame_done;
        t_status status;
    } t_flags;

endpackage

[rtl/ndhp_core.sv]
`include "nested_der_header_parser_macros.svh"

module ndhp_core
    import ndhp_pkg::*;
#(
    parameter int LEN_BYTES_MAX = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  logic [7:0] i_data_byte,
    input  logic       i_first,
    output logic [7:0] o_payload_byte,
    output t_flags     o_flags
);

    localparam int AccW = 8 * LEN_BYTES_MAX;
    localparam int CntW = $clog2(LEN_BYTES_MAX + 1);

    typedef enum logic [11:0] {
        PH_IDLE    = 12'h001,
        PH_OUT_LEN = 12'h002,
        PH_OUT_EXT = 12'h004,
        PH_CTX_TAG = 12'h008,
        PH_CTX_LEN = 12'h010,
        PH_CTX_EXT = 12'h020,
        PH_OCT_TAG = 12'h040,
        PH_OCT_LEN = 12'h080,
        PH_OCT_EXT = 12'h100,
        PH_PAYLOAD = 12'h200,
        PH_DONE    = 12'h400,
        PH_ERROR   = 12'h800
    } t_phase;

    typedef enum logic [1:0] {
        LVL_OUTER = 2'd0,
        LVL_CTX   = 2'd1,
        LVL_OCT   = 2'd2
    } t_level;

    t_phase            r_phase, n_phase;
    logic [CntW-1:0]   r_bytes_left, n_bytes_left;
    logic [AccW-1:0]   r_accum, n_accum;
    logic [AccW-1:0]   r_payload_left, n_payload_left;

    logic              l_len_first;
    logic              l_len_more;
    t_level            l_level;
    logic              l_complete;
    logic [AccW-1:0]   l_len;
    logic [7:0]        l_count;

    // Level of the header whose length is being read.
    always_comb begin
        l_len_first = 1'b0;
        l_len_more  = 1'b0;
        l_level     = LVL_OUTER;
        unique case (r_phase)
            PH_OUT_LEN: begin l_len_first = 1'b1; l_level = LVL_OUTER; end
            PH_OUT_EXT: begin l_len_more  = 1'b1; l_level = LVL_OUTER; end
            PH_CTX_LEN: begin l_len_first = 1'b1; l_level = LVL_CTX;   end
            PH_CTX_EXT: begin l_len_more  = 1'b1; l_level = LVL_CTX;   end
            PH_OCT_LEN: begin l_len_first = 1'b1; l_level = LVL_OCT;   end
            PH_OCT_EXT: begin l_len_more  = 1'b1; l_level = LVL_OCT;   end
            default: begin
                l_len_first = 1'b0;
            end
        endcase
    end

    assign l_count = i_data_byte & LEN_COUNT_MASK;

    // Next-state and result logic for one beat.
    always_comb begin
        n_phase        = r_phase;
        n_bytes_left   = r_bytes_left;
        n_accum        = r_accum;
        n_payload_left = r_payload_left;
        o_payload_byte = 8'h00;
        o_flags        = '{payload_valid: 1'b0, payload_last: 1'b0,
                           frame_done: 1'b0, status: ST_OK};
        l_complete     = 1'b0;
        l_len          = '0;

        if (i_first) begin
            // A first beat restarts the parse from any phase.
            n_bytes_left   = '0;
            n_accum        = '0;
            n_payload_left = '0;
            if (i_data_byte == TAG_SEQUENCE) begin
                n_phase = PH_OUT_LEN;
            end else begin
                o_flags.status = ST_BAD_OUTER;
                n_phase        = PH_ERROR;
            end
        end else if (l_len_first) begin
            n_accum = '0;
            if (i_data_byte > LEN_LONG_MARK) begin
                if (l_count > 8'(LEN_BYTES_MAX)) begin
                    o_flags.status = ST_TOO_LONG;
                    n_phase        = PH_ERROR;
                end else begin
                    n_bytes_left = l_count[CntW-1:0];
                    unique case (l_level)
                        LVL_OUTER: n_phase = PH_OUT_EXT;
                        LVL_CTX:   n_phase = PH_CTX_EXT;
                        default:   n_phase = PH_OCT_EXT;
                    endcase
                end
            end else begin
                n_accum    = AccW'(i_data_byte);
                l_len      = AccW'(i_data_byte);
                l_complete = 1'b1;
            end
        end else if (l_len_more) begin
            // Long-form length bytes arrive most significant first.
            n_accum      = (r_accum << 8) | AccW'(i_data_byte);
            n_bytes_left = r_bytes_left - CntW'(1);
            l_len        = n_accum;
            l_complete   = (r_bytes_left == CntW'(1));
        end else if (r_phase == PH_PAYLOAD) begin
            o_payload_byte        = i_data_byte;
            o_flags.payload_valid = 1'b1;
            n_payload_left        = r_payload_left - AccW'(1);
            if (r_payload_left == AccW'(1)) begin
                o_flags.payload_last = 1'b1;
                o_flags.frame_done   = 1'b1;
                n_phase              = PH_DONE;
            end
        end else if (r_phase == PH_CTX_TAG) begin
            if (i_data_byte == TAG_CONTEXT) begin
                n_phase = PH_CTX_LEN;
            end else begin
                o_flags.status = ST_BAD_CTX;
                n_phase        = PH_ERROR;
            end
        end else if (r_phase == PH_OCT_TAG) begin
            if (i_data_byte == TAG_OCTET) begin
                n_phase = PH_OCT_LEN;
            end else begin
                o_flags.status = ST_BAD_OCT;
                n_phase        = PH_ERROR;
            end
        end

        // A finished length moves on to the next header or the payload.
        if (l_complete) begin
            unique case (l_level)
                LVL_OUTER: n_phase = PH_CTX_TAG;
                LVL_CTX:   n_phase = PH_OCT_TAG;
                default: begin
                    n_payload_left = l_len;
                    if (l_len == '0) begin
                        o_flags.frame_done = 1'b1;
                        n_phase            = PH_DONE;
                    end else begin
                        n_phase = PH_PAYLOAD;
                    end
                end
            endcase
        end
    end

    // Parse state advances once per beat.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_IDLE;
            r_bytes_left   <= '0;
            r_accum        <= '0;
            r_payload_left <= '0;
        end else if (i_step) begin
            r_phase        <= n_phase;
            r_bytes_left   <= n_bytes_left;
            r_accum        <= n_accum;
            r_payload_left <= n_payload_left;
        end
    end

    `NDHP_ASSERT_NOW(a_payload_only_in_payload, i_clk, i_rst_n,
        o_flags.payload_valid, r_phase == PH_PAYLOAD && !i_first,
        "payload beat outside payload phase")
    `NDHP_ASSERT_NOW(a_payload_count_nonzero, i_clk, i_rst_n,
        r_phase == PH_PAYLOAD, r_payload_left != '0,
        "payload phase with zero bytes left")
    `NDHP_ASSERT_NEXT(a_error_enters_error, i_clk, i_rst_n,
        i_step && o_flags.status != ST_OK, r_phase == PH_ERROR,
        "error status without error phase")
    `NDHP_ASSERT_NEXT(a_done_enters_done, i_clk, i_rst_n,
        i_step && o_flags.frame_done, r_phase == PH_DONE,
        "frame done without done phase")

endmodule

[rtl/nested_der_header_parser.sv]
// Streaming parser for a nested DER header (SEQUENCE 0x30, context [0] 0xa0, OCTET STRING
// 0x04), each tag followed by a short- or long-form length of up to LEN_BYTES_MAX bytes;
// the length byte 0x80 is read as the short length 128. Send one byte per beat with
// s_axis_tuser set on the first byte of a message. Every input beat yields exactly one
// output beat, one to one: m_axis_tdata carries the byte only when it is payload (else zero),
// tlast marks the final payload byte, and tuser carries payload valid, frame done (also on
// the last header byte of an empty payload) and an error status on the byte that causes it.
// After an error, and after the payload, bytes are ignored until the next first byte.
// Throughput is one byte per clock while m_axis_tready does not hold the output; an input
// register and an output register sit around a parse state that is updated once per byte.
module nested_der_header_parser
    import ndhp_pkg::*;
#(
    parameter int LEN_BYTES_MAX = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
    input  logic       s_axis_tuser,   // [0] first
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] payload_byte
    output logic       m_axis_tlast,   // payload_last
    output logic [4:0] m_axis_tuser    // [0] payload_valid, [1] frame_done, [4:2] status
);

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_first;
    logic       r_out_valid;
    logic [7:0] r_out_byte;
    t_flags     r_out_flags;

    logic       l_out_free;
    logic       l_step;
    logic [7:0] l_payload_byte;
    t_flags     l_flags;

    // The input stage moves on whenever the output register is empty or being drained.
    assign l_out_free    = !r_out_valid || m_axis_tready;
    assign l_step        = r_in_valid && l_out_free;
    assign s_axis_tready = !r_in_valid || l_out_free;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_byte  <= s_axis_tdata;
            r_in_first <= s_axis_tuser;
        end
    end

    ndhp_core #(
        .LEN_BYTES_MAX (LEN_BYTES_MAX)
    ) u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_step         (l_step),
        .i_data_byte    (r_in_byte),
        .i_first        (r_in_first),
        .o_payload_byte (l_payload_byte),
        .o_flags        (l_flags)
    );

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (l_out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (l_step) begin
            r_out_byte  <= l_payload_byte;
            r_out_flags <= l_flags;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_byte;
    assign m_axis_tlast  = r_out_flags.payload_last;
    assign m_axis_tuser  = {r_out_flags.status, r_out_flags.frame_done,
                            r_out_flags.payload_valid};

endmodule

[sim/der_parse_monitor.sv]
`timescale 1ns / 1ps

// Watches both stream channels of the DER header parser. Every accepted input beat is run
// through a cycle-free model of the parse and the predicted result is queued. Every accepted
// output beat is compared field by field with the oldest prediction.
module der_parse_monitor
    import ndhp_pkg::*;
#(
    parameter int LEN_BYTES_MAX = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    input  logic       i_s_tready,
    input  logic [7:0] i_s_tdata,     // [7:0] data_byte
    input  logic       i_s_tuser,     // [0] first
    input  logic       i_m_tvalid,
    input  logic       i_m_tready,
    input  logic [7:0] i_m_tdata,     // [7:0] payload_byte
    input  logic       i_m_tlast,     // payload_last
    input  logic [4:0] i_m_tuser,     // [0] payload_valid, [1] frame_done, [4:2] status
    output int         o_errors,
    output int         o_outstanding
);

    typedef enum logic [3:0] {
        HDR_IDLE,
        SEQ_LEN,
        SEQ_LEN_EXT,
        CTX_TAG,
        CTX_LEN,
        CTX_LEN_EXT,
        OCT_TAG,
        OCT_LEN,
        OCT_LEN_EXT,
        PAYLOAD,
        TRAILER,
        DROP
    } t_parse_phase;

    typedef struct packed {
        logic [7:0] payload_byte;
        logic       payload_valid;
        logic       payload_last;
        logic       frame_done;
        t_status    status;
    } t_parse_result;

    t_parse_phase  phase;
    logic [2:0]    len_left;
    logic [31:0]   len_accum;
    logic [31:0]   payload_left;
    t_parse_result parse_results_q[$];

    // Advances the parse by one byte and returns the result beat it should produce.
    function automatic t_parse_result parse_der_byte(input logic [7:0] b, input logic first);
        t_parse_result res;
        logic          len_complete;
        res          = '0;
        res.status   = ST_OK;
        len_complete = 1'b0;
        if (first) begin
            // A first byte restarts the parse from any phase.
            len_left     = '0;
            len_accum    = '0;
            payload_left = '0;
            if (b == TAG_SEQUENCE) begin
                phase = SEQ_LEN;
            end else begin
                res.status = ST_BAD_OUTER;
                phase      = DROP;
            end
        end else begin
            case (phase)
                SEQ_LEN, CTX_LEN, OCT_LEN: begin
                    len_accum = '0;
                    if (b > LEN_LONG_MARK) begin
                        if (int'(b & LEN_COUNT_MASK) > LEN_BYTES_MAX) begin
                            res.status = ST_TOO_LONG;
                            phase      = DROP;
                        end else begin
                            len_left = b[2:0];
                            phase    = (phase == SEQ_LEN) ? SEQ_LEN_EXT :
                                       (phase == CTX_LEN) ? CTX_LEN_EXT : OCT_LEN_EXT;
                        end
                    end else begin
                        // Short form, which includes the mark value itself.
                        len_accum    = {24'd0, b};
                        len_complete = 1'b1;
                    end
                end
                SEQ_LEN_EXT, CTX_LEN_EXT, OCT_LEN_EXT: begin
                    len_accum    = {len_accum[23:0], b};
                    len_left     = len_left - 3'd1;
                    len_complete = (len_left == 3'd0);
                end
                CTX_TAG: begin
                    if (b == TAG_CONTEXT) begin
                        phase = CTX_LEN;
                    end else begin
                        res.status = ST_BAD_CTX;
                        phase      = DROP;
                    end
                end
                OCT_TAG: begin
                    if (b == TAG_OCTET) begin
                        phase = OCT_LEN;
                    end else begin
                        res.status = ST_BAD_OCT;
                        phase      = DROP;
                    end
                end
                PAYLOAD: begin
                    res.payload_byte  = b;
                    res.payload_valid = 1'b1;
                    payload_left      = payload_left - 32'd1;
                    if (payload_left == 32'd0) begin
                        res.payload_last = 1'b1;
                        res.frame_done   = 1'b1;
                        phase            = TRAILER;
                    end
                end
                default: begin
                end
            endcase
        end

        // A finished length moves to the next header; only the innermost one is kept.
        if (len_complete) begin
            case (phase)
                SEQ_LEN, SEQ_LEN_EXT: phase = CTX_TAG;
                CTX_LEN, CTX_LEN_EXT: phase = OCT_TAG;
                default: begin
                    payload_left = len_accum;
                    if (len_accum == 32'd0) begin
                        res.frame_done = 1'b1;
                        phase          = TRAILER;
                    end else begin
                        phase = PAYLOAD;
                    end
                end
            endcase
        end
        return res;
    endfunction

    // Predict on input beats and compare on output beats.
    always @(posedge i_clk) begin : watch
        t_parse_result want;
        if (!i_rst_n) begin
            phase        = HDR_IDLE;
            len_left     = '0;
            len_accum    = '0;
            payload_left = '0;
            parse_results_q.delete();
            o_errors     = 0;
        end else begin
            if (i_s_tvalid && i_s_tready) begin
                parse_results_q.push_back(parse_der_byte(i_s_tdata, i_s_tuser));
            end
            if (i_m_tvalid && i_m_tready) begin
                if (parse_results_q.size() == 0) begin
                    $error("result beat with nothing pending: tdata %0h tlast %0b tuser %0h",
                           i_m_tdata, i_m_tlast, i_m_tuser);
                    o_errors++;
                end else begin
                    want = parse_results_q.pop_front();
                    if (i_m_tdata !== want.payload_byte) begin
                        $error("payload_byte: expected %0h, got %0h",
                               want.payload_byte, i_m_tdata);
                        o_errors++;
                    end
                    if (i_m_tuser[0] !== want.payload_valid) begin
                        $error("payload_valid: expected %0b, got %0b",
                               want.payload_valid, i_m_tuser[0]);
                        o_errors++;
                    end
                    if (i_m_tlast !== want.payload_last) begin
                        $error("payload_last: expected %0b, got %0b",
                               want.payload_last, i_m_tlast);
                        o_errors++;
                    end
                    if (i_m_tuser[1] !== want.frame_done) begin
                        $error("frame_done: expected %0b, got %0b",
                               want.frame_done, i_m_tuser[1]);
                        o_errors++;
                    end
                    if (i_m_tuser[4:2] !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, i_m_tuser[4:2]);
                        o_errors++;
                    end
                end
            end
        end
        o_outstanding = parse_results_q.size();
    end

endmodule

[sim/tb.sv]
`timescale 1ns / 1ps

// Drives byte streams into the DER header parser, directed frames first and then random
// frames, most of them well formed and the rest corrupted, cut short or plain noise. Both
// sides idle at random, and the receiver holds off once for a long stretch. The monitor
// does all checking; this module makes stimulus and gives the verdict.
module tb;
    import ndhp_pkg::*;

    localparam int LEN_BYTES_MAX = 4;
    localparam int N_ITEMS       = 1300;
    localparam int QUIET_TAIL    = 150;
    localparam int HOLD_CYCLES   = 200;
    localparam int HOLD_AT       = 400;
    localparam int DRAIN_CYCLES  = 8;
    localparam int STALL_LIMIT   = 2000;

    localparam logic [7:0] HDR_TAGS [3] = '{TAG_SEQUENCE, TAG_CONTEXT, TAG_OCTET};

    typedef struct packed {
        logic       first;
        logic [7:0] data;
    } t_in_beat;

    logic       clk;
    logic       rst_n;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;    // [7:0] data_byte
    logic       s_tuser;    // [0] first
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;    // [7:0] payload_byte
    logic       m_tlast;    // payload_last
    logic [4:0] m_tuser;    // [0] payload_valid, [1] frame_done, [4:2] status

    int         mismatches;
    int         outstanding;
    int         sent_count;
    int         quiet_cycles;
    t_in_beat   msg_q[$];

    nested_der_header_parser #(
        .LEN_BYTES_MAX(LEN_BYTES_MAX)
    ) u_dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .s_axis_tvalid(s_tvalid),
        .s_axis_tready(s_tready),
        .s_axis_tdata (s_tdata),
        .s_axis_tuser (s_tuser),
        .m_axis_tvalid(m_tvalid),
        .m_axis_tready(m_tready),
        .m_axis_tdata (m_tdata),
        .m_axis_tlast (m_tlast),
        .m_axis_tuser (m_tuser)
    );

    der_parse_monitor #(
        .LEN_BYTES_MAX(LEN_BYTES_MAX)
    ) u_monitor (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tlast    (m_tlast),
        .i_m_tuser    (m_tuser),
        .o_errors     (mismatches),
        .o_outstanding(outstanding)
    );

    always #6 clk = ~clk;

    // Idling is off in every fourth stretch of 128 sent bytes and for the whole tail of the run.
    function automatic bit idling_on();
        return (sent_count < N_ITEMS - QUIET_TAIL) && ((sent_count / 128) % 4 != 3);
    endfunction

    task automatic push_byte(input logic first, input logic [7:0] data);
        msg_q.push_back('{first: first, data: data});
    endtask

    // Encodes a length in short form on most draws where it fits, else in a long form of random size.
    task automatic push_length(input logic [31:0] len_val);
        int unsigned need;
        int unsigned n;
        need = (len_val > 32'hffffff) ? 4 : (len_val > 32'hffff) ? 3 :
               (len_val > 32'hff) ? 2 : 1;
        if (len_val <= 32'(LEN_LONG_MARK) && $urandom_range(0, 3) != 0) begin
            push_byte(1'b0, len_val[7:0]);
        end else begin
            n = $urandom_range(need, LEN_BYTES_MAX);
            push_byte(1'b0, LEN_LONG_MARK | 8'(n));
            for (int i = int'(n) - 1; i >= 0; i--) begin
                push_byte(1'b0, len_val[8*i +: 8]);
            end
        end
    endtask

    // Sends every queued byte, one beat each, with random gaps in front of some beats.
    task automatic drive_beats();
        t_in_beat beat;
        while (msg_q.size() != 0) begin
            beat = msg_q.pop_front();
            if (idling_on() && $urandom_range(0, 5) == 0) begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 3)) @(negedge clk);
            end
            s_tvalid <= 1'b1;
            s_tdata  <= beat.data;
            s_tuser  <= beat.first;
            do @(posedge clk); while (!s_tready);
            sent_count++;
            @(negedge clk);
        end
    endtask

    // Receiver: short random stalls, and one long hold-off while the sender keeps offering.
    initial begin : sink
        bit held_off;
        held_off = 1'b0;
        m_tready = 1'b0;
        forever begin
            @(negedge clk);
            if (!held_off && sent_count >= HOLD_AT) begin
                held_off = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
            end else if (idling_on() && $urandom_range(0, 5) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 3) - 1) @(negedge clk);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Watchdog: ends the run if neither channel moves a beat for too long.
    always @(posedge clk) begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : stimulus
        int          kind;
        int          lvl;
        int          keep;
        int          tag_pos [3];
        int          len_pos [3];
        logic [31:0] plen;
        logic [7:0]  bad;

        clk          = 1'b0;
        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = 1'b0;
        sent_count   = 0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Stray byte while idle, then a bad outer tag.
        push_byte(1'b0, 8'hff);
        push_byte(1'b1, 8'h31);
        // Over-long length form, then a byte ignored in the error state.
        push_byte(1'b1, TAG_SEQUENCE); push_byte(1'b0, 8'h85);
        push_byte(1'b0, 8'h00);
        // Bad context tag.
        push_byte(1'b1, TAG_SEQUENCE); push_byte(1'b0, 8'h00); push_byte(1'b0, 8'ha1);
        // Bad octet-string tag.
        push_byte(1'b1, TAG_SEQUENCE); push_byte(1'b0, 8'h00);
        push_byte(1'b0, TAG_CONTEXT); push_byte(1'b0, 8'h7f); push_byte(1'b0, 8'h05);
        // Length byte equal to the long-form mark, a four-byte long form, a two-byte
        // payload with extreme values, and a trailing byte after the payload.
        push_byte(1'b1, TAG_SEQUENCE); push_byte(1'b0, LEN_LONG_MARK);
        push_byte(1'b0, TAG_CONTEXT); push_byte(1'b0, 8'h84);
        push_byte(1'b0, 8'hff); push_byte(1'b0, 8'h00);
        push_byte(1'b0, 8'h00); push_byte(1'b0, 8'h01);
        push_byte(1'b0, TAG_OCTET); push_byte(1'b0, 8'h02);
        push_byte(1'b0, 8'h00); push_byte(1'b0, 8'hff);
        push_byte(1'b0, 8'h5a);
        drive_beats();

        // Random frames: mostly well formed, the rest corrupted, cut short or noise.
        while (sent_count < N_ITEMS) begin
            kind = $urandom_range(0, 9);
            if (kind == 9) begin
                repeat ($urandom_range(1, 4)) push_byte($urandom_range(0, 3) == 0, 8'($urandom));
            end else begin
                tag_pos[0] = msg_q.size();
                push_byte(1'b1, TAG_SEQUENCE);
                len_pos[0] = msg_q.size();
                push_length(($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 200));
                tag_pos[1] = msg_q.size();
                push_byte(1'b0, TAG_CONTEXT);
                len_pos[1] = msg_q.size();
                push_length(($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 200));
                tag_pos[2] = msg_q.size();
                push_byte(1'b0, TAG_OCTET);
                len_pos[2] = msg_q.size();
                case ($urandom_range(0, 19))
                    0:       plen = 32'(LEN_LONG_MARK);
                    1:       plen = $urandom_range(129, 300);
                    2:       plen = $urandom();
                    default: plen = $urandom_range(0, 12);
                endcase
                push_length(plen);
                // Huge payloads are abandoned early by the next first byte.
                repeat ((plen > 300) ? $urandom_range(0, 6) : plen) begin
                    push_byte(1'b0, 8'($urandom));
                end
                repeat ($urandom_range(0, 2)) push_byte(1'b0, 8'($urandom));

                lvl  = $urandom_range(0, 2);
                keep = msg_q.size();
                case (kind)
                    6: begin
                        do bad = 8'($urandom); while (bad == HDR_TAGS[lvl]);
                        msg_q[tag_pos[lvl]].data = bad;
                        keep = tag_pos[lvl] + 1 + $urandom_range(0, 2);
                    end
                    7: begin
                        msg_q[len_pos[lvl]].data = 8'($urandom_range(
                            int'(LEN_LONG_MARK) + LEN_BYTES_MAX + 1, 255));
                        keep = len_pos[lvl] + 1 + $urandom_range(0, 2);
                    end
                    8: keep = $urandom_range(1, msg_q.size() - 1);
                    default: begin
                    end
                endcase
                while (msg_q.size() > keep) void'(msg_q.pop_back());
            end
            drive_beats();
        end
        s_tvalid <= 1'b0;

        // Let every predicted beat arrive, then watch a little longer for strays.
        while (outstanding != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
